FILE: rtl/core/circle_pair_collision_resolve_assert.svh
// Assertion macros for the circle pair collision block.
// Depends on nothing; included by the files that carry assertions.
`ifndef CIRCLE_PAIR_COLLISION_RESOLVE_ASSERT_SVH
`define CIRCLE_PAIR_COLLISION_RESOLVE_ASSERT_SVH
`ifndef SYNTHESIS
`define CPCR_ASSERT(lbl, clk, rst, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("cpcr assertion failed");
`define CPCR_ASSERT_IMPLY(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("cpcr implication failed");
`else
`define CPCR_ASSERT(lbl, clk, rst, prop)
`define CPCR_ASSERT_IMPLY(lbl, clk, rst, ante, cons)
`endif
`endif

FILE: rtl/core/cpcr_pkg.sv
// Shared widths, item, context and result types and saturation for the collision block.
// Depends on nothing.
package cpcr_pkg;

  localparam int FRAC_BITS = 16;
  localparam int PF_W      = 16;
  localparam logic [PF_W-1:0] PF_RESET = 16'd49152;
  localparam int COORD_W   = 32;
  localparam int RAD_W     = 31;
  localparam int RSUM_W    = 32;
  localparam int DIFF_W    = 33;
  localparam int SQ_W      = 66;
  localparam int ROOT_W    = 33;
  localparam int REM_W     = ROOT_W + 3;
  localparam int QUO_W     = FRAC_BITS + 1;
  localparam int NORM_W    = QUO_W + 1;
  localparam int PEN_W     = 32;
  localparam int DV_W      = DIFF_W + FRAC_BITS + 1;
  localparam int SAT_W     = 35;

  typedef struct packed {
    logic signed [COORD_W-1:0] a_pos_x;
    logic signed [COORD_W-1:0] a_pos_y;
    logic [RAD_W-1:0]          a_radius;
    logic signed [COORD_W-1:0] a_vel_x;
    logic signed [COORD_W-1:0] a_vel_y;
    logic signed [COORD_W-1:0] b_pos_x;
    logic signed [COORD_W-1:0] b_pos_y;
    logic [RAD_W-1:0]          b_radius;
    logic signed [COORD_W-1:0] b_vel_x;
    logic signed [COORD_W-1:0] b_vel_y;
    logic                      same_body;
  } item_t;

  typedef struct packed {
    item_t             item;
    logic              touching;
    logic              coincident;
    logic              dx_neg;
    logic              dy_neg;
    logic [DIFF_W-1:0] dx_mag;
    logic [DIFF_W-1:0] dy_mag;
    logic [RSUM_W-1:0] rsum;
  } ctx_t;

  typedef struct packed {
    logic               touching;
    logic               resolved;
    logic               coincident;
    logic [COORD_W-1:0] new_a_pos_x;
    logic [COORD_W-1:0] new_a_pos_y;
    logic [COORD_W-1:0] new_a_vel_x;
    logic [COORD_W-1:0] new_a_vel_y;
    logic [COORD_W-1:0] new_b_pos_x;
    logic [COORD_W-1:0] new_b_pos_y;
    logic [COORD_W-1:0] new_b_vel_x;
    logic [COORD_W-1:0] new_b_vel_y;
  } res_t;

  function automatic logic [COORD_W-1:0] sat32(input logic signed [SAT_W-1:0] v);
    logic [COORD_W-1:0] r;
    if (!v[SAT_W-1] && (v[SAT_W-2:COORD_W-1] != '0)) begin
      r = 32'h7fff_ffff;
    end else if (v[SAT_W-1] && (v[SAT_W-2:COORD_W-1] != '1)) begin
      r = 32'h8000_0000;
    end else begin
      r = v[COORD_W-1:0];
    end
    return r;
  endfunction

endpackage

FILE: rtl/core/cpcr_front.sv
// Front stages: centre difference, squares and the overlap test.
// Depends on cpcr_pkg.
module cpcr_front (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        adv,
  input  logic                        in_valid,
  input  cpcr_pkg::item_t             in_item,
  output logic                        out_valid,
  output cpcr_pkg::ctx_t              out_ctx,
  output logic [cpcr_pkg::SQ_W-1:0]   out_d2
);
  import cpcr_pkg::*;

  logic                     v1, v2;
  item_t                    item1, item2;
  logic signed [DIFF_W-1:0] dx1, dy1;
  logic [RSUM_W-1:0]        rs1, rs2;
  logic [DIFF_W-1:0]        dx_mag, dy_mag, dx_mag2, dy_mag2;
  logic                     dx_neg2, dy_neg2;
  logic [SQ_W-1:0]          dx_sq2, dy_sq2, d2;
  logic [2*RSUM_W-1:0]      rs_sq2;
  logic                     touch;

  assign dx_mag = dx1[DIFF_W-1] ? -dx1 : dx1;
  assign dy_mag = dy1[DIFF_W-1] ? -dy1 : dy1;
  assign d2     = dx_sq2 + dy_sq2;
  assign touch  = !item2.same_body && (d2 <= {2'b00, rs_sq2});

  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      v2        <= 1'b0;
      out_valid <= 1'b0;
    end else if (adv) begin
      v1        <= in_valid;
      v2        <= v1;
      out_valid <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      item1 <= in_item;
      dx1   <= $signed({in_item.b_pos_x[COORD_W-1], in_item.b_pos_x})
             - $signed({in_item.a_pos_x[COORD_W-1], in_item.a_pos_x});
      dy1   <= $signed({in_item.b_pos_y[COORD_W-1], in_item.b_pos_y})
             - $signed({in_item.a_pos_y[COORD_W-1], in_item.a_pos_y});
      rs1   <= {1'b0, in_item.a_radius} + {1'b0, in_item.b_radius};

      item2   <= item1;
      dx_neg2 <= dx1[DIFF_W-1];
      dy_neg2 <= dy1[DIFF_W-1];
      dx_mag2 <= dx_mag;
      dy_mag2 <= dy_mag;
      dx_sq2  <= dx_mag * dx_mag;
      dy_sq2  <= dy_mag * dy_mag;
      rs2     <= rs1;
      rs_sq2  <= rs1 * rs1;

      out_ctx.item       <= item2;
      out_ctx.touching   <= touch;
      out_ctx.coincident <= touch && (d2 == '0);
      out_ctx.dx_neg     <= dx_neg2;
      out_ctx.dy_neg     <= dy_neg2;
      out_ctx.dx_mag     <= dx_mag2;
      out_ctx.dy_mag     <= dy_mag2;
      out_ctx.rsum       <= rs2;
      out_d2             <= d2;
    end
  end

endmodule

FILE: rtl/core/cpcr_sqrt.sv
// Pipelined integer square root, one result bit per stage.
// Depends on cpcr_pkg.
module cpcr_sqrt (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        adv,
  input  logic                        in_valid,
  input  cpcr_pkg::ctx_t              in_ctx,
  input  logic [cpcr_pkg::SQ_W-1:0]   in_rad,
  output logic                        out_valid,
  output cpcr_pkg::ctx_t              out_ctx,
  output logic [cpcr_pkg::ROOT_W-1:0] out_root
);
  import cpcr_pkg::*;

  typedef struct packed {
    ctx_t              ctx;
    logic [SQ_W-1:0]   rad;
    logic [ROOT_W-1:0] root;
    logic [REM_W-1:0]  rem;
  } sq_t;

  sq_t               st_q  [ROOT_W];
  sq_t               st_in [ROOT_W];
  logic [ROOT_W-1:0] v_q;
  logic [ROOT_W-1:0] v_in;

  genvar s;
  generate
    for (s = 0; s < ROOT_W; s++) begin : g_step
      logic [REM_W-1:0] rem_sh;
      logic [REM_W-1:0] trial;
      logic             ge;

      if (s == 0) begin : g_first
        assign st_in[s] = '{ctx: in_ctx, rad: in_rad, root: '0, rem: '0};
        assign v_in[s]  = in_valid;
      end else begin : g_next
        assign st_in[s] = st_q[s-1];
        assign v_in[s]  = v_q[s-1];
      end

      assign rem_sh = {st_in[s].rem[REM_W-3:0], st_in[s].rad[SQ_W-1 -: 2]};
      assign trial  = {1'b0, st_in[s].root, 2'b01};
      assign ge     = rem_sh >= trial;

      always_ff @(posedge clk) begin
        if (rst) begin
          v_q[s] <= 1'b0;
        end else if (adv) begin
          v_q[s] <= v_in[s];
        end
      end

      always_ff @(posedge clk) begin
        if (adv) begin
          st_q[s].ctx  <= st_in[s].ctx;
          st_q[s].rad  <= {st_in[s].rad[SQ_W-3:0], 2'b00};
          st_q[s].root <= {st_in[s].root[ROOT_W-2:0], ge};
          st_q[s].rem  <= ge ? rem_sh - trial : rem_sh;
        end
      end
    end
  endgenerate

  assign out_valid = v_q[ROOT_W-1];
  assign out_ctx   = st_q[ROOT_W-1].ctx;
  assign out_root  = st_q[ROOT_W-1].root;

endmodule

FILE: rtl/core/cpcr_div.sv
// Pipelined restoring divider for both normal components, one quotient bit a stage.
// Depends on cpcr_pkg.
module cpcr_div (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        adv,
  input  logic                        in_valid,
  input  cpcr_pkg::ctx_t              in_ctx,
  input  logic [cpcr_pkg::ROOT_W-1:0] in_root,
  output logic                        out_valid,
  output cpcr_pkg::ctx_t              out_ctx,
  output logic [cpcr_pkg::QUO_W-1:0]  out_qx,
  output logic [cpcr_pkg::QUO_W-1:0]  out_qy,
  output logic [cpcr_pkg::PEN_W-1:0]  out_pen
);
  import cpcr_pkg::*;

  typedef struct packed {
    ctx_t              ctx;
    logic [PEN_W-1:0]  pen;
    logic [ROOT_W-1:0] dlen;
    logic [DV_W-1:0]   rx;
    logic [DV_W-1:0]   ry;
    logic [QUO_W-1:0]  qx;
    logic [QUO_W-1:0]  qy;
  } dv_t;

  dv_t              st_q  [QUO_W];
  dv_t              st_in [QUO_W];
  logic [QUO_W-1:0] v_q;
  logic [QUO_W-1:0] v_in;
  logic [ROOT_W-1:0] dlen0;
  logic [ROOT_W:0]   pen_full;

  assign dlen0    = (in_root == '0) ? ROOT_W'(1) : in_root;
  assign pen_full = {2'b00, in_ctx.rsum} - {1'b0, in_root};

  genvar s;
  generate
    for (s = 0; s < QUO_W; s++) begin : g_step
      localparam int K = QUO_W - 1 - s;
      logic [DV_W-1:0] dsh;
      logic            ge_x, ge_y;

      if (s == 0) begin : g_first
        assign st_in[s] = '{ctx: in_ctx, pen: pen_full[PEN_W-1:0], dlen: dlen0,
                            rx: {1'b0, in_ctx.dx_mag, {FRAC_BITS{1'b0}}},
                            ry: {1'b0, in_ctx.dy_mag, {FRAC_BITS{1'b0}}},
                            qx: '0, qy: '0};
        assign v_in[s]  = in_valid;
      end else begin : g_next
        assign st_in[s] = st_q[s-1];
        assign v_in[s]  = v_q[s-1];
      end

      assign dsh  = DV_W'(st_in[s].dlen) << K;
      assign ge_x = st_in[s].rx >= dsh;
      assign ge_y = st_in[s].ry >= dsh;

      always_ff @(posedge clk) begin
        if (rst) begin
          v_q[s] <= 1'b0;
        end else if (adv) begin
          v_q[s] <= v_in[s];
        end
      end

      always_ff @(posedge clk) begin
        if (adv) begin
          st_q[s].ctx  <= st_in[s].ctx;
          st_q[s].pen  <= st_in[s].pen;
          st_q[s].dlen <= st_in[s].dlen;
          st_q[s].rx   <= ge_x ? st_in[s].rx - dsh : st_in[s].rx;
          st_q[s].ry   <= ge_y ? st_in[s].ry - dsh : st_in[s].ry;
          st_q[s].qx   <= {st_in[s].qx[QUO_W-2:0], ge_x};
          st_q[s].qy   <= {st_in[s].qy[QUO_W-2:0], ge_y};
        end
      end
    end
  endgenerate

  assign out_valid = v_q[QUO_W-1];
  assign out_ctx   = st_q[QUO_W-1].ctx;
  assign out_qx    = st_q[QUO_W-1].qx;
  assign out_qy    = st_q[QUO_W-1].qy;
  assign out_pen   = st_q[QUO_W-1].pen;

endmodule

FILE: rtl/core/cpcr_resolve.sv
// Closing speed, push-apart amounts, saturation and the output register.
// Depends on cpcr_pkg.
module cpcr_resolve (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       adv,
  input  logic                       in_valid,
  input  cpcr_pkg::ctx_t             in_ctx,
  input  logic [cpcr_pkg::QUO_W-1:0] in_qx,
  input  logic [cpcr_pkg::QUO_W-1:0] in_qy,
  input  logic [cpcr_pkg::PEN_W-1:0] in_pen,
  input  logic [cpcr_pkg::PF_W-1:0]  push_fraction,
  output logic                       out_valid,
  output cpcr_pkg::res_t             out_res
);
  import cpcr_pkg::*;

  localparam int PROD_W = DIFF_W + NORM_W;
  localparam int VN_W   = PROD_W + 1;
  localparam int MP_W   = QUO_W + PEN_W;
  localparam int PP_W   = DIFF_W + PF_W;

  logic                      v1, v2;
  ctx_t                      ctx1, ctx2;
  logic signed [NORM_W-1:0]  nx, ny;
  logic signed [DIFF_W-1:0]  dvx, dvy;
  logic signed [PROD_W-1:0]  prod_x1, prod_y1;
  logic [MP_W-1:0]           mx_full, my_full;
  logic [DIFF_W-1:0]         mp_x1, mp_y1, px2, py2;
  logic signed [VN_W-1:0]    vn;
  logic [PP_W-1:0]           ppx_full, ppy_full;
  logic                      vn_le2;
  logic                      resolve;
  logic signed [SAT_W-1:0]   pxs, pys;
  item_t                     it;

  assign nx  = in_ctx.dx_neg ? -$signed({1'b0, in_qx}) : $signed({1'b0, in_qx});
  assign ny  = in_ctx.dy_neg ? -$signed({1'b0, in_qy}) : $signed({1'b0, in_qy});
  assign dvx = $signed({in_ctx.item.b_vel_x[COORD_W-1], in_ctx.item.b_vel_x})
             - $signed({in_ctx.item.a_vel_x[COORD_W-1], in_ctx.item.a_vel_x});
  assign dvy = $signed({in_ctx.item.b_vel_y[COORD_W-1], in_ctx.item.b_vel_y})
             - $signed({in_ctx.item.a_vel_y[COORD_W-1], in_ctx.item.a_vel_y});
  assign mx_full = in_qx * in_pen;
  assign my_full = in_qy * in_pen;

  assign vn = $signed({prod_x1[PROD_W-1], prod_x1}) + $signed({prod_y1[PROD_W-1], prod_y1});
  assign ppx_full = mp_x1 * push_fraction;
  assign ppy_full = mp_y1 * push_fraction;

  assign it      = ctx2.item;
  assign resolve = ctx2.touching && !ctx2.coincident && vn_le2;
  assign pxs     = ctx2.dx_neg ? -$signed({2'b00, px2}) : $signed({2'b00, px2});
  assign pys     = ctx2.dy_neg ? -$signed({2'b00, py2}) : $signed({2'b00, py2});

  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      v2        <= 1'b0;
      out_valid <= 1'b0;
    end else if (adv) begin
      v1        <= in_valid;
      v2        <= v1;
      out_valid <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      ctx1    <= in_ctx;
      prod_x1 <= dvx * nx;
      prod_y1 <= dvy * ny;
      mp_x1   <= mx_full[MP_W-1:FRAC_BITS];
      mp_y1   <= my_full[MP_W-1:FRAC_BITS];

      ctx2   <= ctx1;
      vn_le2 <= vn[VN_W-1] || (vn == '0);
      px2    <= ppx_full[PP_W-1:PF_W];
      py2    <= ppy_full[PP_W-1:PF_W];

      out_res.touching   <= ctx2.touching;
      out_res.coincident <= ctx2.coincident;
      out_res.resolved   <= resolve;
      if (resolve) begin
        out_res.new_a_pos_x <= sat32(SAT_W'(it.a_pos_x) - pxs);
        out_res.new_a_pos_y <= sat32(SAT_W'(it.a_pos_y) - pys);
        out_res.new_b_pos_x <= sat32(SAT_W'(it.b_pos_x) + pxs);
        out_res.new_b_pos_y <= sat32(SAT_W'(it.b_pos_y) + pys);
        out_res.new_a_vel_x <= sat32(-SAT_W'(it.a_vel_x));
        out_res.new_a_vel_y <= sat32(-SAT_W'(it.a_vel_y));
        out_res.new_b_vel_x <= sat32(-SAT_W'(it.b_vel_x));
        out_res.new_b_vel_y <= sat32(-SAT_W'(it.b_vel_y));
      end else begin
        out_res.new_a_pos_x <= it.a_pos_x;
        out_res.new_a_pos_y <= it.a_pos_y;
        out_res.new_b_pos_x <= it.b_pos_x;
        out_res.new_b_pos_y <= it.b_pos_y;
        out_res.new_a_vel_x <= it.a_vel_x;
        out_res.new_a_vel_y <= it.a_vel_y;
        out_res.new_b_vel_x <= it.b_vel_x;
        out_res.new_b_vel_y <= it.b_vel_y;
      end
    end
  end

endmodule

FILE: rtl/core/circle_pair_collision_resolve.sv
// Pipeline from input transfer to result: front, root, divide and resolve stages.
// Throughput: one pair per cycle; every stage is a register and all advance together
// whenever the output register is empty or its result is being taken.
// Reset clears all valid bits and loads push_fraction with 0.75 (49152).
// Depends on cpcr_pkg, cpcr_front, cpcr_sqrt, cpcr_div, cpcr_resolve and the assert header.
`include "circle_pair_collision_resolve_assert.svh"
module circle_pair_collision_resolve (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_we,
  input  logic [cpcr_pkg::PF_W-1:0]   cfg_wdata,
  input  logic                        s_tvalid,
  output logic                        s_tready,
  // a_pos_x, a_pos_y, a_radius, a_vel_x, a_vel_y, b_pos_x, b_pos_y, b_radius, b_vel_x,
  // b_vel_y, zero pad
  input  logic [319:0]                s_tdata,
  // same_body
  input  logic [0:0]                  s_tuser,
  output logic                        m_tvalid,
  input  logic                        m_tready,
  // new_a_pos_x, new_a_pos_y, new_a_vel_x, new_a_vel_y, new_b_pos_x, new_b_pos_y,
  // new_b_vel_x, new_b_vel_y
  output logic [255:0]                m_tdata,
  // touching, resolved, coincident
  output logic [2:0]                  m_tuser
);
  import cpcr_pkg::*;

  logic [PF_W-1:0]   push_fraction;
  logic              adv;
  item_t             item;
  logic              f_valid, q_valid, d_valid;
  ctx_t              f_ctx, q_ctx, d_ctx;
  logic [SQ_W-1:0]   f_d2;
  logic [ROOT_W-1:0] q_root;
  logic [QUO_W-1:0]  d_qx, d_qy;
  logic [PEN_W-1:0]  d_pen;
  res_t              res;

  always_ff @(posedge clk) begin
    if (rst) begin
      push_fraction <= PF_RESET;
    end else if (cfg_we) begin
      push_fraction <= cfg_wdata;
    end
  end

  assign adv      = !m_tvalid || m_tready;
  assign s_tready = adv;

  assign item.a_pos_x   = s_tdata[31:0];
  assign item.a_pos_y   = s_tdata[63:32];
  assign item.a_radius  = s_tdata[94:64];
  assign item.a_vel_x   = s_tdata[126:95];
  assign item.a_vel_y   = s_tdata[158:127];
  assign item.b_pos_x   = s_tdata[190:159];
  assign item.b_pos_y   = s_tdata[222:191];
  assign item.b_radius  = s_tdata[253:223];
  assign item.b_vel_x   = s_tdata[285:254];
  assign item.b_vel_y   = s_tdata[317:286];
  assign item.same_body = s_tuser[0];

  cpcr_front u_front (
    .clk(clk), .rst(rst), .adv(adv), .in_valid(s_tvalid), .in_item(item),
    .out_valid(f_valid), .out_ctx(f_ctx), .out_d2(f_d2)
  );

  cpcr_sqrt u_sqrt (
    .clk(clk), .rst(rst), .adv(adv), .in_valid(f_valid), .in_ctx(f_ctx), .in_rad(f_d2),
    .out_valid(q_valid), .out_ctx(q_ctx), .out_root(q_root)
  );

  cpcr_div u_div (
    .clk(clk), .rst(rst), .adv(adv), .in_valid(q_valid), .in_ctx(q_ctx), .in_root(q_root),
    .out_valid(d_valid), .out_ctx(d_ctx), .out_qx(d_qx), .out_qy(d_qy), .out_pen(d_pen)
  );

  cpcr_resolve u_resolve (
    .clk(clk), .rst(rst), .adv(adv), .in_valid(d_valid), .in_ctx(d_ctx),
    .in_qx(d_qx), .in_qy(d_qy), .in_pen(d_pen), .push_fraction(push_fraction),
    .out_valid(m_tvalid), .out_res(res)
  );

  assign m_tuser = {res.coincident, res.resolved, res.touching};
  assign m_tdata = {res.new_b_vel_y, res.new_b_vel_x, res.new_b_pos_y, res.new_b_pos_x,
                    res.new_a_vel_y, res.new_a_vel_x, res.new_a_pos_y, res.new_a_pos_x};

  `CPCR_ASSERT_IMPLY(a_resolved_touching, clk, rst, m_tvalid && m_tuser[1], m_tuser[0])
  `CPCR_ASSERT_IMPLY(a_coincident_unresolved, clk, rst, m_tvalid && m_tuser[2], m_tuser[0] && !m_tuser[1])
  `CPCR_ASSERT(a_empty_takes_input, clk, rst, !m_tvalid |-> s_tready)

endmodule

FILE: tb/sv/cpcr_checker.sv
`timescale 1ns / 100ps
// Checker for the circle pair collision block: predicts each result and compares it.
// Depends on cpcr_pkg; watches the stream and configuration ports of the block.
module cpcr_checker (
  input  logic         clk,
  input  logic         rst,
  input  logic         cfg_we,
  input  logic [15:0]  cfg_wdata,
  input  logic         s_tvalid,
  input  logic         s_tready,
  input  logic [319:0] s_tdata,
  input  logic [0:0]   s_tuser,
  input  logic         m_tvalid,
  input  logic         m_tready,
  input  logic [255:0] m_tdata,
  input  logic [2:0]   m_tuser,
  output int           errors,
  output int           pending,
  output int           n_touch,
  output int           n_resolved,
  output int           n_coincident
);
  import cpcr_pkg::*;

  typedef struct packed {
    logic [2:0]   flags;
    logic [255:0] words;
  } outcome_t;

  logic [15:0] push_share;
  outcome_t    outcomes_due[$];

  function automatic longint clamp32(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic longint push_step(longint n, logic [63:0] pen, logic [15:0] pf);
    logic [63:0] m;
    m = ((n < 0) ? -n : n);
    m = (m * pen) >> FRAC_BITS;
    m = (m * {48'd0, pf}) >> 16;
    return (n < 0) ? -longint'(m) : longint'(m);
  endfunction

  function automatic outcome_t resolve_pair(item_t it, logic [15:0] pf);
    longint      ax, ay, avx, avy, bx, by, bvx, bvy, dx, dy, nx, ny, vn, px, py;
    logic [63:0] adx, ady, rs, dlen, c, pen;
    logic [127:0] d2;
    bit          tch, coin, res;
    outcome_t    o;
    ax = it.a_pos_x; ay = it.a_pos_y; avx = it.a_vel_x; avy = it.a_vel_y;
    bx = it.b_pos_x; by = it.b_pos_y; bvx = it.b_vel_x; bvy = it.b_vel_y;
    dx = bx - ax;
    dy = by - ay;
    adx = (dx < 0) ? -dx : dx;
    ady = (dy < 0) ? -dy : dy;
    rs = 64'(it.a_radius) + 64'(it.b_radius);
    d2 = 128'(adx) * 128'(adx) + 128'(ady) * 128'(ady);
    tch = !it.same_body && (d2 <= 128'(rs) * 128'(rs));
    coin = tch && (d2 == 0);
    res = 0;
    if (tch && !coin) begin
      dlen = 0;
      for (int b = 33; b >= 0; b--) begin
        c = dlen | (64'd1 << b);
        if (128'(c) * 128'(c) <= d2) dlen = c;
      end
      if (dlen == 0) dlen = 1;
      nx = longint'((adx << FRAC_BITS) / dlen);
      ny = longint'((ady << FRAC_BITS) / dlen);
      if (dx < 0) nx = -nx;
      if (dy < 0) ny = -ny;
      pen = (rs >= dlen) ? rs - dlen : 0;
      vn = (bvx - avx) * nx + (bvy - avy) * ny;
      if (vn <= 0) begin
        px = push_step(nx, pen, pf);
        py = push_step(ny, pen, pf);
        ax = clamp32(ax - px);
        ay = clamp32(ay - py);
        bx = clamp32(bx + px);
        by = clamp32(by + py);
        avx = clamp32(-avx);
        avy = clamp32(-avy);
        bvx = clamp32(-bvx);
        bvy = clamp32(-bvy);
        res = 1;
      end
    end
    o.flags = {coin, res, tch};
    o.words = {bvy[31:0], bvx[31:0], by[31:0], bx[31:0],
               avy[31:0], avx[31:0], ay[31:0], ax[31:0]};
    return o;
  endfunction

  function automatic item_t unpack_pair(logic [319:0] d, logic u);
    item_t it;
    it.a_pos_x = d[31:0];
    it.a_pos_y = d[63:32];
    it.a_radius = d[94:64];
    it.a_vel_x = d[126:95];
    it.a_vel_y = d[158:127];
    it.b_pos_x = d[190:159];
    it.b_pos_y = d[222:191];
    it.b_radius = d[253:223];
    it.b_vel_x = d[285:254];
    it.b_vel_y = d[317:286];
    it.same_body = u;
    return it;
  endfunction

  string word_name[8] = '{"new_a_pos_x", "new_a_pos_y", "new_a_vel_x", "new_a_vel_y",
                          "new_b_pos_x", "new_b_pos_y", "new_b_vel_x", "new_b_vel_y"};

  assign pending = outcomes_due.size();

  always @(posedge clk) begin
    outcome_t want;
    int       bad;
    bad = 0;
    if (rst) begin
      push_share <= PF_RESET;
      outcomes_due.delete();
      errors <= 0;
      n_touch <= 0;
      n_resolved <= 0;
      n_coincident <= 0;
    end else begin
      if (cfg_we) push_share <= cfg_wdata;
      if (s_tvalid && s_tready)
        outcomes_due.insert(outcomes_due.size(),
                            resolve_pair(unpack_pair(s_tdata, s_tuser[0]), push_share));
      if (m_tvalid && m_tready) begin
        if (outcomes_due.size() == 0) begin
          $display("%0t: unexpected result flags=%b data=%h", $time, m_tuser, m_tdata);
          bad = bad + 1;
        end else begin
          want = outcomes_due.pop_front();
          if (want.flags !== m_tuser) begin
            $display("%0t: flags (coincident,resolved,touching) expected %b actual %b",
                     $time, want.flags, m_tuser);
            bad = bad + 1;
          end
          for (int i = 0; i < 8; i++)
            if (want.words[i*32 +: 32] !== m_tdata[i*32 +: 32]) begin
              $display("%0t: %s expected %h actual %h", $time, word_name[i],
                       want.words[i*32 +: 32], m_tdata[i*32 +: 32]);
              bad = bad + 1;
            end
          n_touch <= n_touch + m_tuser[0];
          n_resolved <= n_resolved + m_tuser[1];
          n_coincident <= n_coincident + m_tuser[2];
        end
      end
      errors <= errors + bad;
    end
  end
endmodule

FILE: tb/sv/tb_top.sv
`timescale 1ns / 100ps
// Top of the testbench for circle_pair_collision_resolve: clock, reset, stimulus, verdict.
// Depends on cpcr_pkg, the block itself and cpcr_checker.
module tb_top;
  import cpcr_pkg::*;

  localparam int STALL_LIMIT = 5000;

  logic         clk, rst, cfg_we, s_tvalid, s_tready, m_tvalid, m_tready;
  logic [15:0]  cfg_wdata;
  logic [319:0] s_tdata;
  logic [0:0]   s_tuser;
  logic [255:0] m_tdata;
  logic [2:0]   m_tuser;
  int errors, pending, n_touch, n_resolved, n_coincident;
  int tx_idle_pct = 0, rx_stall_pct = 0, hold_cycles = 0, quiet = 0, n_sent = 0;

  circle_pair_collision_resolve i_dut (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
  );

  cpcr_checker i_checker (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
    .errors(errors), .pending(pending), .n_touch(n_touch), .n_resolved(n_resolved),
    .n_coincident(n_coincident)
  );

  initial begin
    clk = 0;
    forever #6 clk = ~clk;
  end

  initial begin
    m_tready = 0;
    forever begin
      @(negedge clk);
      if (hold_cycles > 0) begin
        m_tready <= 0;
        hold_cycles--;
      end else begin
        m_tready <= ($urandom_range(99) >= rx_stall_pct);
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) quiet <= 0;
    else quiet <= quiet + 1;
    if (quiet >= STALL_LIMIT) begin
      $display("%0t: no transfer for %0d cycles", $time, STALL_LIMIT);
      $display("tb: failure");
      $finish;
    end
  end

  function automatic logic [319:0] pack_pair(item_t it);
    return {2'b00, it.b_vel_y, it.b_vel_x, it.b_radius, it.b_pos_y, it.b_pos_x,
            it.a_vel_y, it.a_vel_x, it.a_radius, it.a_pos_y, it.a_pos_x};
  endfunction

  task automatic send(item_t it);
    while ($urandom_range(99) < tx_idle_pct) begin
      s_tvalid <= 0;
      @(negedge clk);
    end
    s_tvalid <= 1;
    s_tdata <= pack_pair(it);
    s_tuser <= it.same_body;
    do @(posedge clk); while (!s_tready);
    @(negedge clk);
    n_sent++;
  endtask

  task automatic settle();
    s_tvalid <= 0;
    while (pending != 0) @(negedge clk);
    repeat (60) @(negedge clk);
  endtask

  task automatic write_push(logic [15:0] v);
    cfg_we <= 1;
    cfg_wdata <= v;
    @(negedge clk);
    cfg_we <= 0;
  endtask

  function automatic logic [31:0] small_val(int span);
    return 32'($urandom_range(2 * span) - span);
  endfunction

  function automatic item_t random_pair();
    item_t        it;
    int           k;
    logic [319:0] raw;
    k = $urandom_range(99);
    it = '{default: '0};
    if (k < 20) begin
      raw = {$urandom, $urandom, $urandom, $urandom, $urandom,
             $urandom, $urandom, $urandom, $urandom, $urandom};
      it = item_t'(raw[318:0]);
    end else begin
      it.a_pos_x = small_val(1 << 20);
      it.a_pos_y = small_val(1 << 20);
      it.b_pos_x = it.a_pos_x + small_val(1 << 17);
      it.b_pos_y = it.a_pos_y + small_val(1 << 17);
      if (k < 30) begin
        it.a_pos_x = 32'h7fff_0000 + small_val(1 << 15);
        it.a_pos_y = 32'h8000_ffff + small_val(1 << 15);
        it.b_pos_x = it.a_pos_x + small_val(1 << 16);
        it.b_pos_y = it.a_pos_y + small_val(1 << 16);
      end
      if (k >= 30 && k < 35) begin
        it.b_pos_x = it.a_pos_x;
        it.b_pos_y = it.a_pos_y;
      end
      it.a_radius = (k < 30) ? 31'($urandom_range(1 << 30)) : 31'($urandom_range(1 << 17));
      it.b_radius = (k < 30) ? 31'($urandom_range(1 << 30)) : 31'($urandom_range(1 << 17));
      it.a_vel_x = $urandom_range(3) == 0 ? $urandom : small_val(1 << 18);
      it.a_vel_y = $urandom_range(3) == 0 ? $urandom : small_val(1 << 18);
      it.b_vel_x = $urandom_range(3) == 0 ? $urandom : small_val(1 << 18);
      it.b_vel_y = $urandom_range(3) == 0 ? $urandom : small_val(1 << 18);
      it.same_body = ($urandom_range(19) == 0);
    end
    return it;
  endfunction

  task automatic directed_pairs();
    item_t it;
    it = '{default: '0};
    send(it);
    it.same_body = 1'b1;
    send(it);
    it = '{a_pos_x: 0, a_pos_y: 0, a_radius: 31'h0001_0000, a_vel_x: 32'h0001_0000,
           a_vel_y: 0, b_pos_x: 32'h0001_0000, b_pos_y: 0, b_radius: 31'h0001_0000,
           b_vel_x: 32'hffff_0000, b_vel_y: 0, same_body: 0};
    send(it);
    it.a_vel_x = 32'hffff_0000;
    it.b_vel_x = 32'h0001_0000;
    send(it);
    it.same_body = 1'b1;
    send(it);
    it = '{a_pos_x: 32'h8000_0000, a_pos_y: 32'h8000_0000, a_radius: 31'h7fff_ffff,
           a_vel_x: 32'h8000_0000, a_vel_y: 32'h7fff_ffff, b_pos_x: 32'h7fff_ffff,
           b_pos_y: 32'h7fff_ffff, b_radius: 31'h7fff_ffff, b_vel_x: 32'h8000_0000,
           b_vel_y: 32'h8000_0000, same_body: 0};
    send(it);
    it.b_pos_x = 32'h8000_0010;
    it.b_pos_y = 32'h8000_0000;
    send(it);
    it.a_pos_x = 32'h7fff_fff0;
    it.a_pos_y = 32'h7fff_ffff;
    it.b_pos_x = 32'h7fff_ffff;
    it.b_pos_y = 32'h7fff_ffff;
    it.a_vel_x = 32'h7fff_ffff;
    send(it);
    it.b_pos_x = it.a_pos_x;
    send(it);
    it = '{a_pos_x: 0, a_pos_y: 0, a_radius: 1, a_vel_x: 0, a_vel_y: 0,
           b_pos_x: 3, b_pos_y: 0, b_radius: 1, b_vel_x: 0, b_vel_y: 0, same_body: 0};
    send(it);
    it.b_pos_x = 2;
    send(it);
    it.b_pos_x = 32'hffff_fffe;
    it.b_pos_y = 1;
    send(it);
    it = '{a_pos_x: 32'h0010_0000, a_pos_y: 32'hfff0_0000, a_radius: 31'h0008_0000,
           a_vel_x: 0, a_vel_y: 32'h0002_0000, b_pos_x: 32'h000c_0000, b_pos_y: 32'hfff4_0000,
           b_radius: 31'h0008_0000, b_vel_x: 32'h0001_8000, b_vel_y: 0, same_body: 0};
    send(it);
    it.a_vel_x = 32'h8000_0000;
    send(it);
    for (int i = 0; i < 6; i++) send(random_pair());
  endtask

  initial begin
    logic [15:0] push_values[4];
    int idle_tx[4];
    int idle_rx[4];
    push_values = '{16'd49152, 16'hffff, 16'h0000, 16'h0000};
    idle_tx = '{0, 74, 0, 34};
    idle_rx = '{0, 0, 74, 34};
    rst = 1;
    cfg_we = 0;
    cfg_wdata = 0;
    s_tvalid = 0;
    s_tdata = '0;
    s_tuser = '0;
    push_values[3] = 16'($urandom);
    repeat (6) @(negedge clk);
    rst = 0;
    directed_pairs();
    for (int p = 0; p < 4; p++) begin
      settle();
      if (p != 0) write_push(push_values[p]);
      tx_idle_pct = idle_tx[p];
      rx_stall_pct = idle_rx[p];
      if (p == 0) hold_cycles = 300;
      for (int i = 0; i < 220; i++) send(random_pair());
      if (p == 1) begin
        settle();
        write_push(16'd1);
        for (int i = 0; i < 20; i++) send(random_pair());
      end
    end
    settle();
    $display("Sent %0d circle pairs over four push fractions and idling phases.", n_sent);
    $display("Results: %0d touching, %0d resolved, %0d coincident.",
             n_touch, n_resolved, n_coincident);
    if (errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end
endmodule

FILE: files.f
+incdir+rtl/core
rtl/core/cpcr_pkg.sv
rtl/core/cpcr_front.sv
rtl/core/cpcr_sqrt.sv
rtl/core/cpcr_div.sv
rtl/core/cpcr_resolve.sv
rtl/core/circle_pair_collision_resolve.sv
tb/sv/cpcr_checker.sv
tb/sv/tb_top.sv
